// ----- rtl/bbr_pkg.sv -----
package bbr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = 10;
  localparam int unsigned STEP_W   = 6;
  localparam int unsigned OFFSET_W = 16;
  localparam int unsigned POS_W    = 16;
  localparam int unsigned BYTE_W   = 13;
  localparam int unsigned BIB_W    = 3;
  localparam int unsigned OFF_W    = 5;

  typedef enum logic [2:0] {
    OP_LOAD    = 3'd0,
    OP_SET_POS = 3'd1,
    OP_SHOW    = 3'd2,
    OP_GET     = 3'd3,
    OP_FLUSH   = 3'd4,
    OP_REWIND  = 3'd5,
    OP_ALIGN   = 3'd6,
    OP_REPORT  = 3'd7
  } op_t;

  typedef logic [WORD_W-1:0] word_t;

endpackage

// ----- rtl/bitstream_bit_reader.sv -----
// MSB-first bit reader over a two-bank word store (even and odd words), so
// the two words under the read position come out of one synchronous read.
// One item is taken per cycle while the output is not stalled; each result
// passes the store read register and then the output register, which holds
// a result while the next item is already taken. The position register is
// updated as the item is taken, so back-to-back reads see the moved position.
// Loads write the store at once and a read in the next cycle sees the word.
// Moves saturate at zero and at STORE_WORDS*32 bits and set out_of_range;
// bits past the store read as zero. Reading a word never loaded gives
// undefined bits.
module bitstream_bit_reader #(
  parameter int unsigned STORE_WORDS   = 1024,
  parameter int unsigned MAX_READ_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [2:0]                   opcode,
  input  logic [bbr_pkg::ADDR_W-1:0]   word_addr,
  input  logic [bbr_pkg::WORD_W-1:0]   word_data,
  input  logic [bbr_pkg::STEP_W-1:0]   step_bits,
  input  logic [bbr_pkg::OFFSET_W-1:0] seek_bits,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bbr_pkg::WORD_W-1:0]   bits_value,
  output logic [bbr_pkg::POS_W-1:0]    bit_position,
  output logic [bbr_pkg::BYTE_W-1:0]   byte_count,
  output logic [bbr_pkg::BIB_W-1:0]    bit_in_byte,
  output logic                         out_of_range
);

  localparam int unsigned END_BITS = STORE_WORDS * 32;
  localparam int unsigned PW       = $clog2(END_BITS + 1);
  localparam int unsigned IDX_W    = PW - bbr_pkg::OFF_W;

  bbr_pkg::op_t               op;
  logic                       accept;
  logic                       s1_move;
  logic [bbr_pkg::STEP_W-1:0] n_clamp;
  logic [PW:0]                sum;
  logic [PW:0]                aligned;
  logic                       is_read;

  logic [PW-1:0]              pos;
  logic [PW-1:0]              pos_next;
  logic                       flag_next;

  logic                       s1_valid;
  logic                       s1_read;
  logic [bbr_pkg::OFF_W-1:0]  s1_off;
  logic [bbr_pkg::STEP_W-1:0] s1_n;
  logic [PW-1:0]              s1_pos;
  logic                       s1_flag;

  logic [PW-1:0]              out_pos;
  logic [31:0]                out_pos_x;

  bbr_pkg::word_t             w0;
  bbr_pkg::word_t             w1;
  bbr_pkg::word_t             funnel_value;

  assign op       = bbr_pkg::op_t'(opcode);
  assign s1_move  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_move;
  assign accept   = in_valid && in_ready;
  assign is_read  = (op == bbr_pkg::OP_SHOW) || (op == bbr_pkg::OP_GET);

  assign n_clamp = (step_bits > bbr_pkg::STEP_W'(MAX_READ_BITS)) ?
                   bbr_pkg::STEP_W'(MAX_READ_BITS) : step_bits;
  assign sum     = {1'b0, pos} + (PW+1)'(n_clamp);
  assign aligned = {1'b0, pos} + (PW+1)'(7);

  always_comb begin
    pos_next  = pos;
    flag_next = 1'b0;
    unique case (op)
      bbr_pkg::OP_LOAD, bbr_pkg::OP_SHOW, bbr_pkg::OP_REPORT: begin
        pos_next = pos;
      end
      bbr_pkg::OP_SET_POS: begin
        if (32'(seek_bits) > 32'(END_BITS)) begin
          pos_next  = PW'(END_BITS);
          flag_next = 1'b1;
        end else begin
          pos_next = PW'(seek_bits);
        end
      end
      bbr_pkg::OP_GET, bbr_pkg::OP_FLUSH: begin
        if (sum > (PW+1)'(END_BITS)) begin
          pos_next  = PW'(END_BITS);
          flag_next = 1'b1;
        end else begin
          pos_next = sum[PW-1:0];
        end
      end
      bbr_pkg::OP_REWIND: begin
        if (32'(seek_bits) > 32'(pos)) begin
          pos_next  = '0;
          flag_next = 1'b1;
        end else begin
          pos_next = pos - PW'(seek_bits);
        end
      end
      bbr_pkg::OP_ALIGN: begin
        pos_next = {aligned[PW-1:3], 3'b000};
      end
      default: begin
        pos_next = pos;
      end
    endcase
  end

  bbr_store #(
    .STORE_WORDS(STORE_WORDS),
    .IDX_W      (IDX_W)
  ) u_store (
    .clk    (clk),
    .wr_en  (accept && (op == bbr_pkg::OP_LOAD)),
    .wr_addr(word_addr),
    .wr_data(word_data),
    .rd_en  (accept && is_read),
    .rd_idx (pos[PW-1:bbr_pkg::OFF_W]),
    .w0     (w0),
    .w1     (w1)
  );

  bbr_funnel u_funnel (
    .w0   (w0),
    .w1   (w1),
    .off  (s1_off),
    .n    (s1_n),
    .value(funnel_value)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      s1_valid <= 1'b0;
    end else begin
      if (accept) begin
        pos      <= pos_next;
        s1_valid <= 1'b1;
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_read <= is_read;
      s1_off  <= pos[bbr_pkg::OFF_W-1:0];
      s1_n    <= n_clamp;
      s1_pos  <= pos_next;
      s1_flag <= flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      bits_value   <= s1_read ? funnel_value : '0;
      out_pos      <= s1_pos;
      out_of_range <= s1_flag;
    end
  end

  assign out_pos_x    = 32'(out_pos);
  assign bit_position = out_pos_x[bbr_pkg::POS_W-1:0];
  assign byte_count   = out_pos_x[bbr_pkg::BYTE_W+2:3];
  assign bit_in_byte  = out_pos_x[2:0];

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    32'(pos) <= 32'(END_BITS))
    else $error("position beyond store end");

  a_pos_hold: assert property (@(posedge clk) disable iff (rst)
    accept && (op == bbr_pkg::OP_SHOW || op == bbr_pkg::OP_LOAD || op == bbr_pkg::OP_REPORT)
    |=> pos == $past(pos))
    else $error("position moved on a non-moving item");

  a_flag_ops: assert property (@(posedge clk) disable iff (rst)
    accept && (op == bbr_pkg::OP_SHOW || op == bbr_pkg::OP_LOAD ||
               op == bbr_pkg::OP_ALIGN || op == bbr_pkg::OP_REPORT)
    |=> !s1_flag)
    else $error("range flag on a command that cannot saturate");

  a_s1_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_move |=> s1_valid && $stable(s1_pos) && $stable(s1_off))
    else $error("stage item lost while output stalled");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> s1_valid && out_valid && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule

// ----- rtl/bbr_store.sv -----
module bbr_store #(
  parameter int unsigned STORE_WORDS = 1024,
  parameter int unsigned IDX_W       = 10
) (
  input  logic                       clk,
  input  logic                       wr_en,
  input  logic [bbr_pkg::ADDR_W-1:0] wr_addr,
  input  bbr_pkg::word_t             wr_data,
  input  logic                       rd_en,
  input  logic [IDX_W-1:0]           rd_idx,
  output bbr_pkg::word_t             w0,
  output bbr_pkg::word_t             w1
);

  localparam int unsigned ROWS = (STORE_WORDS + 1) / 2;
  localparam int unsigned RW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned WAW  = RW + 1;

  bbr_pkg::word_t even_mem [ROWS];
  bbr_pkg::word_t odd_mem  [ROWS];

  logic [WAW-1:0]   wa;
  logic             wr_ok;
  logic [IDX_W:0]   idx_x;
  logic [IDX_W:0]   even_full;
  logic [IDX_W:0]   odd_full;
  logic [RW-1:0]    even_row;
  logic [RW-1:0]    odd_row;
  logic             ok0;
  logic             ok1;

  bbr_pkg::word_t   even_q;
  bbr_pkg::word_t   odd_q;
  logic             swap_q;
  logic             ok0_q;
  logic             ok1_q;

  assign wa        = WAW'(wr_addr);
  assign wr_ok     = wr_en && (32'(wr_addr) < 32'(STORE_WORDS));
  assign idx_x     = {1'b0, rd_idx};
  assign even_full = (idx_x + (IDX_W+1)'(1)) >> 1;
  assign odd_full  = idx_x >> 1;
  assign even_row  = even_full[RW-1:0];
  assign odd_row   = odd_full[RW-1:0];
  assign ok0       = 32'(idx_x) < 32'(STORE_WORDS);
  assign ok1       = (32'(idx_x) + 32'd1) < 32'(STORE_WORDS);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      if (wa[0]) begin
        odd_mem[wa[RW:1]] <= wr_data;
      end else begin
        even_mem[wa[RW:1]] <= wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      even_q <= even_mem[even_row];
      odd_q  <= odd_mem[odd_row];
      swap_q <= rd_idx[0];
      ok0_q  <= ok0;
      ok1_q  <= ok1;
    end
  end

  assign w0 = ok0_q ? (swap_q ? odd_q : even_q) : '0;
  assign w1 = ok1_q ? (swap_q ? even_q : odd_q) : '0;

endmodule

// ----- rtl/bbr_funnel.sv -----
module bbr_funnel (
  input  bbr_pkg::word_t              w0,
  input  bbr_pkg::word_t              w1,
  input  logic [bbr_pkg::OFF_W-1:0]   off,
  input  logic [bbr_pkg::STEP_W-1:0]  n,
  output bbr_pkg::word_t              value
);

  localparam logic [bbr_pkg::STEP_W-1:0] WIDTH_N = bbr_pkg::STEP_W'(bbr_pkg::WORD_W);

  logic [2*bbr_pkg::WORD_W-1:0] pair;
  bbr_pkg::word_t               head;
  logic [bbr_pkg::STEP_W-1:0]   rshift;

  assign pair   = {w0, w1} << off;
  assign head   = pair[2*bbr_pkg::WORD_W-1:bbr_pkg::WORD_W];
  assign rshift = WIDTH_N - n;
  assign value  = (n == '0) ? '0 : (head >> rshift);

endmodule
